### rtl/lzsswd_pkg.sv
// Shared types and constants for the LZSS window decoder.
// No dependencies; the decoder and its checker both import this package.
package lzsswd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [23:0] count_type;
   typedef logic [0:0]  csr_idx_type;

   // Configuration register indexes.
   localparam csr_idx_type CSR_SCRAMBLED  = 1'b0;
   localparam csr_idx_type CSR_OUT_LENGTH = 1'b1;

   localparam count_type OUT_LENGTH_RESET = 24'hFF_FFFF;
   localparam byte_type  FLAG_XOR         = 8'hC8;
   localparam int        DIST_BITS        = 12;
   localparam logic [4:0] LEN_BIAS        = 5'd2;

   // Token descrambling key, selected by bits 5..3 of the raw flag byte.
   function automatic logic [15:0] token_key(input logic [2:0] sel);
      logic [15:0] key;
      unique case (sel)
         3'd0: key = 16'hFF21;
         3'd1: key = 16'h834F;
         3'd2: key = 16'h675F;
         3'd3: key = 16'h0034;
         3'd4: key = 16'hF237;
         3'd5: key = 16'h815F;
         3'd6: key = 16'h4765;
         default: key = 16'h0233;
      endcase
      return key;
   endfunction

endpackage

### rtl/lzss_window_decoder.sv
// LZSS decoder with a history window held in one synchronous RAM.
// Depends on lzsswd_pkg.
//
//   Channel  Ports                                   Direction  Moves
//   req      req_valid, req_stall, req_in_byte       in         compressed byte
//   rsp      rsp_valid, rsp_stall, rsp_out_byte,     out        decoded byte
//            rsp_run_last
//   csr      csr_valid, csr_ready, csr_index,        in         register write
//            csr_wdata
//
// A flag byte or a low token byte is absorbed without a stall; a literal within the output
// length holds req_stall until it moves on to the output register, then the next is taken.
// A match token of n bytes holds req_stall until its copy is through: the window RAM read
// port delivers one byte per cycle while the copy pipeline is not frozen by a stall on rsp,
// and each byte is written back as it is emitted.
// A window read that hits the entry being written in the same cycle is forwarded.
// Reset is synchronous and clears all control state; the window needs no clearing.
// A stall on rsp holds the output register and freezes the copy pipeline behind it.
module lzss_window_decoder #(
   parameter int WINDOW_DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lzsswd_pkg::byte_type     req_in_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lzsswd_pkg::byte_type     rsp_out_byte,
   output logic                     rsp_run_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  lzsswd_pkg::csr_idx_type  csr_index,
   input  lzsswd_pkg::count_type    csr_wdata
);
   import lzsswd_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   byte_type         win_mem [WINDOW_DEPTH];

   count_type        cnt_ff, cnt_in;
   count_type        olen_ff, olen_in;
   logic             mode_ff, mode_in;
   byte_type         flag_ff, flag_in;
   logic [3:0]       left_ff, left_in;
   logic [2:0]       key_ff, key_in;
   logic             phase_ff, phase_in;
   byte_type         tlow_ff;
   logic [4:0]       rem_ff, rem_in;
   logic [AW-1:0]    rdptr_ff, rdptr_in;
   byte_type         rd_q_ff;

   logic             s1_vld_ff, s1_vld_in;
   logic             s1_mem_ff, s1_mem_in;
   logic             s1_last_ff, s1_last_in;
   logic             s1_fwd_ff, s1_fwd_in;
   byte_type         s1_fdat_ff;
   byte_type         s1_lit_ff;

   logic             rsp_vld_ff, rsp_vld_in;
   byte_type         rsp_byte_ff;
   logic             rsp_last_ff;

   logic             out_free, s1_mv, busy, acc, rd_en, has_room;
   logic             is_flag, is_lit, is_tlow, is_thigh;
   byte_type         s1_byte;
   logic [15:0]      tok;
   logic [4:0]       tok_len, tok_n;
   count_type        room;

   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign s1_mv    = s1_vld_ff && out_free;
   assign busy     = (rem_ff != 5'd0) || s1_vld_ff;
   assign acc      = req_valid && !busy;
   assign rd_en    = (rem_ff != 5'd0) && (!s1_vld_ff || s1_mv);
   assign s1_byte  = s1_mem_ff ? (s1_fwd_ff ? s1_fdat_ff : rd_q_ff) : s1_lit_ff;

   assign is_flag  = acc && (left_ff == 4'd0);
   assign is_lit   = acc && (left_ff != 4'd0) && !phase_ff && !flag_ff[0];
   assign is_tlow  = acc && (left_ff != 4'd0) && !phase_ff && flag_ff[0];
   assign is_thigh = acc && (left_ff != 4'd0) && phase_ff;

   assign tok      = {req_in_byte, tlow_ff} ^ (mode_ff ? token_key(key_ff) : 16'h0000);
   assign tok_len  = {1'b0, tok[15:12]} + LEN_BIAS;
   assign has_room = cnt_ff < olen_ff;
   assign room     = olen_ff - cnt_ff;
   // Bytes past the output length are dropped, so the copy is cut short up front.
   assign tok_n    = !has_room ? 5'd0 :
                     (room < {19'd0, tok_len}) ? room[4:0] : tok_len;

   always_comb begin
      cnt_in     = cnt_ff;
      olen_in    = olen_ff;
      mode_in    = mode_ff;
      flag_in    = flag_ff;
      left_in    = left_ff;
      key_in     = key_ff;
      phase_in   = phase_ff;
      rem_in     = rem_ff;
      rdptr_in   = rdptr_ff;
      s1_vld_in  = s1_vld_ff;
      s1_mem_in  = s1_mem_ff;
      s1_last_in = s1_last_ff;
      s1_fwd_in  = s1_fwd_ff;
      rsp_vld_in = rsp_vld_ff;

      if (s1_mv) begin
         cnt_in     = cnt_ff + 24'd1;
         rsp_vld_in = 1'b1;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end

      if (rd_en) begin
         rem_in     = rem_ff - 5'd1;
         rdptr_in   = rdptr_ff + AW'(1);
         s1_vld_in  = 1'b1;
         s1_mem_in  = 1'b1;
         s1_last_in = (rem_ff == 5'd1);
         s1_fwd_in  = s1_mv && (rdptr_ff == cnt_ff[AW-1:0]);
      end else if (s1_mv) begin
         s1_vld_in  = 1'b0;
      end

      if (is_flag) begin
         flag_in  = mode_ff ? (req_in_byte ^ FLAG_XOR) : req_in_byte;
         key_in   = req_in_byte[5:3];
         left_in  = 4'd8;
         phase_in = 1'b0;
      end
      if (is_lit) begin
         flag_in  = {1'b0, flag_ff[7:1]};
         left_in  = left_ff - 4'd1;
         if (has_room) begin
            s1_vld_in  = 1'b1;
            s1_mem_in  = 1'b0;
            s1_last_in = 1'b1;
         end
      end
      if (is_tlow) begin
         phase_in = 1'b1;
      end
      if (is_thigh) begin
         phase_in = 1'b0;
         flag_in  = {1'b0, flag_ff[7:1]};
         left_in  = left_ff - 4'd1;
         rem_in   = tok_n;
         rdptr_in = cnt_ff[AW-1:0] - AW'(tok[DIST_BITS-1:0]);
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_SCRAMBLED:  mode_in = csr_wdata[0];
            CSR_OUT_LENGTH: olen_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         olen_ff    <= OUT_LENGTH_RESET;
         mode_ff    <= 1'b0;
         flag_ff    <= '0;
         left_ff    <= '0;
         key_ff     <= '0;
         phase_ff   <= 1'b0;
         rem_ff     <= '0;
         rdptr_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         s1_mem_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         s1_fwd_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         olen_ff    <= olen_in;
         mode_ff    <= mode_in;
         flag_ff    <= flag_in;
         left_ff    <= left_in;
         key_ff     <= key_in;
         phase_ff   <= phase_in;
         rem_ff     <= rem_in;
         rdptr_ff   <= rdptr_in;
         s1_vld_ff  <= s1_vld_in;
         s1_mem_ff  <= s1_mem_in;
         s1_last_ff <= s1_last_in;
         s1_fwd_ff  <= s1_fwd_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (is_tlow) begin
         tlow_ff <= req_in_byte;
      end
      if (is_lit) begin
         s1_lit_ff <= req_in_byte;
      end
      if (rd_en) begin
         s1_fdat_ff <= s1_byte;
      end
      if (s1_mv) begin
         rsp_byte_ff <= s1_byte;
         rsp_last_ff <= s1_last_ff;
      end
   end

   // Window RAM: one write and one registered read per cycle, read-first.
   always_ff @(posedge clock) begin
      if (s1_mv) begin
         win_mem[cnt_ff[AW-1:0]] <= s1_byte;
      end
      if (rd_en) begin
         rd_q_ff <= win_mem[rdptr_ff];
      end
   end

   assign req_stall    = busy;
   assign rsp_valid    = rsp_vld_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;
   assign csr_ready    = 1'b1;

endmodule

### rtl/lzsswd_checker.sv
// Port-level checks for the LZSS window decoder, bound to its top level.
// Depends on lzsswd_pkg and lzss_window_decoder.
module lzsswd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input lzsswd_pkg::byte_type  rsp_out_byte,
   input logic                  rsp_run_last
);
   import lzsswd_pkg::*;

   // A stalled response must hold its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))
      else $error("stalled response changed");

   // Reset leaves the decoder idle with no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("decoder not idle after reset");

   // The decoder only becomes busy because of a request it just took.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("request stall rose without an accepted request");

   // After a byte that is not the last of its run, more bytes are still on their way.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid || req_stall)
      else $error("run ended without a last marker");

endmodule

bind lzss_window_decoder lzsswd_checker u_lzsswd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_run_last (rsp_run_last)
);
